/* sv/segregated_free_list_allocator_assert.svh */
// assertion macros for the free-list allocator
`ifndef SEGREGATED_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define SEGREGATED_FREE_LIST_ALLOCATOR_ASSERT_SVH

`ifndef SYNTH

// clocked assertion with explicit clock and active-low reset
`define SFLA_ASSERT_CLK(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("allocator assertion failed");

// clocked assertion on the default clock and reset
`define SFLA_ASSERT(name, prop) \
  `SFLA_ASSERT_CLK(name, clk_i, rst_ni, prop)

`else

`define SFLA_ASSERT_CLK(name, clk, rstn, prop)
`define SFLA_ASSERT(name, prop)

`endif

`endif

/* sv/sfla_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sfla_pkg;

  localparam int SmallClasses  = 16;
  localparam int SmallDepth    = 256;
  localparam int LargeDepth    = 256;
  localparam int MaxBlockWords = 65535;

  localparam int AddrW   = 32;
  localparam int SizeW   = 16;
  localparam int CountW  = 13;
  localparam int StatusW = 2;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_OVERSIZE = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    OP_FREE    = 1'b0,
    OP_REQUEST = 1'b1
  } opcode_e;

endpackage
`default_nettype wire

/* sv/sfla_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface sfla_req_if;
  import sfla_pkg::*;

  logic             valid;
  logic             ready;
  logic             opcode;
  logic [AddrW-1:0] block_address;
  logic [SizeW-1:0] block_size;

  modport source (output valid, opcode, block_address, block_size, input ready);
  modport sink   (input valid, opcode, block_address, block_size, output ready);
endinterface
`default_nettype wire

/* sv/sfla_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface sfla_rsp_if;
  import sfla_pkg::*;

  logic               valid;
  logic               ready;
  logic               granted;
  logic [AddrW-1:0]   granted_address;
  logic [StatusW-1:0] status;
  logic [CountW-1:0]  free_block_count;
  logic [AddrW-1:0]   free_word_total;

  modport source (output valid, granted, granted_address, status, free_block_count,
                  free_word_total, input ready);
  modport sink   (input valid, granted, granted_address, status, free_block_count,
                  free_word_total, output ready);
endinterface
`default_nettype wire

/* sv/segregated_free_list_allocator.sv */
// channel | dir | payload                                         | handshake
// req_i   | in  | opcode, block_address, block_size               | valid/ready
// rsp_o   | out | granted, granted_address, status, counts, words | valid/ready
//
// free and small-class pop: no scan; a pop reads the class stack memory once
// large-list request: a first-fit scan walks the entries in order,
//   one entry per cycle through the large-list memory read port
// reset clears fills, counts and the word sum; the memories keep their contents
// a request is taken only when the engine is idle; a stalled response holds in
//   its output register while the next request is already accepted
`timescale 1ns / 1ps
`default_nettype none
`include "segregated_free_list_allocator_assert.svh"
module segregated_free_list_allocator #(
  parameter int SMALL_CLASSES   = sfla_pkg::SmallClasses,
  parameter int SMALL_DEPTH     = sfla_pkg::SmallDepth,
  parameter int LARGE_DEPTH     = sfla_pkg::LargeDepth,
  parameter int MAX_BLOCK_WORDS = sfla_pkg::MaxBlockWords
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sfla_req_if.sink    req_i,
  sfla_rsp_if.source  rsp_o
);
  import sfla_pkg::*;

  localparam int CLS_W = $clog2(SMALL_CLASSES);
  localparam int FILL_W = $clog2(SMALL_DEPTH + 1);
  localparam int SA_W = $clog2(SMALL_CLASSES * SMALL_DEPTH);
  localparam int LI_W = $clog2(LARGE_DEPTH);
  localparam int LC_W = $clog2(LARGE_DEPTH + 1);
  localparam int LE_W = AddrW + SizeW;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_POP  = 6'b000100,
    S_SCAN = 6'b001000,
    S_MOVE = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // latched request
  logic             op_q;
  logic [AddrW-1:0] addr_q;
  logic [SizeW-1:0] size_q;

  // bookkeeping
  logic [FILL_W-1:0] fill_q [SMALL_CLASSES];
  logic [FILL_W-1:0] fill_d [SMALL_CLASSES];
  logic [LC_W-1:0]   lcnt_q, lcnt_d;
  logic [CountW-1:0] blk_q, blk_d;
  logic [AddrW-1:0]  sum_q, sum_d;
  logic [LI_W-1:0]   idx_q, idx_d;

  // pending result
  logic               res_gnt_q, res_gnt_d;
  logic [AddrW-1:0]   res_addr_q, res_addr_d;
  status_e            res_st_q, res_st_d;

  // output register
  logic               out_valid_q;
  logic               out_gnt_q;
  logic [AddrW-1:0]   out_addr_q;
  logic [StatusW-1:0] out_st_q;
  logic [CountW-1:0]  out_blk_q;
  logic [AddrW-1:0]   out_sum_q;
  logic               out_load;

  // memories
  logic [AddrW-1:0] smem [SMALL_CLASSES * SMALL_DEPTH];
  logic [LE_W-1:0]  lmem [LARGE_DEPTH];
  logic             s_we, s_re, l_we, l_re;
  logic [SA_W-1:0]  s_waddr, s_raddr;
  logic [LI_W-1:0]  l_waddr, l_raddr;
  logic [LE_W-1:0]  l_wdata;
  logic [AddrW-1:0] s_rdata_q;
  logic [LE_W-1:0]  l_rdata_q;

  // decode of the latched request
  logic              is_small;
  logic [CLS_W-1:0]  cls;
  logic [FILL_W-1:0] fill_cur;
  logic [SA_W-1:0]   cls_base;
  logic              oversize;
  logic [AddrW-1:0]  ent_addr;
  logic [SizeW-1:0]  ent_size;
  logic [LC_W-1:0]   last;

  assign is_small = size_q < SizeW'(SMALL_CLASSES);
  assign cls      = size_q[CLS_W-1:0];
  assign fill_cur = fill_q[cls];
  assign cls_base = SA_W'(int'(cls) * SMALL_DEPTH);
  assign oversize = {16'b0, size_q} > 32'(MAX_BLOCK_WORDS);
  assign ent_addr = l_rdata_q[LE_W-1:SizeW];
  assign ent_size = l_rdata_q[SizeW-1:0];
  assign last     = lcnt_q - LC_W'(1);

  assign req_i.ready = (state_q == S_IDLE);

  // engine control
  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    lcnt_d     = lcnt_q;
    blk_d      = blk_q;
    sum_d      = sum_q;
    idx_d      = idx_q;
    res_gnt_d  = res_gnt_q;
    res_addr_d = res_addr_q;
    res_st_d   = res_st_q;
    s_we = 1'b0; s_re = 1'b0; l_we = 1'b0; l_re = 1'b0;
    s_waddr = cls_base + SA_W'(fill_cur);
    s_raddr = cls_base + SA_W'(fill_cur - FILL_W'(1));
    l_waddr = lcnt_q[LI_W-1:0];
    l_raddr = LI_W'(0);
    l_wdata = {addr_q, size_q};
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_gnt_d  = 1'b0;
        res_addr_d = '0;
        res_st_d   = ST_OK;
        state_d    = S_DONE;
        if (op_q == OP_FREE) begin
          if (oversize) begin
            res_st_d = ST_OVERSIZE;
          end else if (size_q == '0) begin
            res_st_d = ST_OK;
          end else if (is_small) begin
            if (fill_cur == FILL_W'(SMALL_DEPTH)) begin
              res_st_d = ST_FULL;
            end else begin
              s_we        = 1'b1;
              fill_d[cls] = fill_cur + FILL_W'(1);
              blk_d       = blk_q + CountW'(1);
              sum_d       = sum_q + AddrW'(size_q);
            end
          end else if (lcnt_q == LC_W'(LARGE_DEPTH)) begin
            res_st_d = ST_FULL;
          end else begin
            l_we   = 1'b1;
            lcnt_d = lcnt_q + LC_W'(1);
            blk_d  = blk_q + CountW'(1);
            sum_d  = sum_q + AddrW'(size_q);
          end
        end else if (size_q != '0) begin
          if (is_small && fill_cur != '0) begin
            s_re        = 1'b1;
            fill_d[cls] = fill_cur - FILL_W'(1);
            blk_d       = blk_q - CountW'(1);
            sum_d       = sum_q - AddrW'(size_q);
            state_d     = S_POP;
          end else if (lcnt_q != '0) begin
            l_re    = 1'b1;
            idx_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_POP: begin
        res_gnt_d  = 1'b1;
        res_addr_d = s_rdata_q;
        state_d    = S_DONE;
      end
      S_SCAN: begin
        if (ent_size >= size_q) begin
          res_gnt_d  = 1'b1;
          res_addr_d = ent_addr;
          sum_d      = sum_q - AddrW'(size_q);
          state_d    = S_DONE;
          if (ent_size > size_q) begin
            l_we    = 1'b1;
            l_waddr = idx_q;
            l_wdata = {ent_addr + AddrW'(size_q), ent_size - size_q};
          end else begin
            lcnt_d = last;
            blk_d  = blk_q - CountW'(1);
            if (LC_W'(idx_q) != last) begin
              l_re    = 1'b1;
              l_raddr = last[LI_W-1:0];
              state_d = S_MOVE;
            end
          end
        end else if (LC_W'(idx_q) + LC_W'(1) == lcnt_q) begin
          state_d = S_DONE;
        end else begin
          l_re    = 1'b1;
          l_raddr = idx_q + LI_W'(1);
          idx_d   = idx_q + LI_W'(1);
        end
      end
      S_MOVE: begin
        l_we    = 1'b1;
        l_waddr = idx_q;
        l_wdata = l_rdata_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '{default: '0};
      lcnt_q      <= '0;
      blk_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      lcnt_q  <= lcnt_d;
      blk_q   <= blk_d;
      sum_q   <= sum_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      op_q   <= req_i.opcode;
      addr_q <= req_i.block_address;
      size_q <= req_i.block_size;
    end
    idx_q      <= idx_d;
    res_gnt_q  <= res_gnt_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    if (out_load) begin
      out_gnt_q  <= res_gnt_q;
      out_addr_q <= res_addr_q;
      out_st_q   <= res_st_q;
      out_blk_q  <= blk_q;
      out_sum_q  <= sum_q;
    end
  end

  // small-class stack memory
  always_ff @(posedge clk_i) begin
    if (s_we) begin
      smem[s_waddr] <= addr_q;
    end
    if (s_re) begin
      s_rdata_q <= smem[s_raddr];
    end
  end

  // large list memory, address and size per entry
  always_ff @(posedge clk_i) begin
    if (l_we) begin
      lmem[l_waddr] <= l_wdata;
    end
    if (l_re) begin
      l_rdata_q <= lmem[l_raddr];
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.granted          = out_gnt_q;
  assign rsp_o.granted_address  = out_addr_q;
  assign rsp_o.status           = out_st_q;
  assign rsp_o.free_block_count = out_blk_q;
  assign rsp_o.free_word_total  = out_sum_q;

  // checks
  `SFLA_ASSERT(a_lcnt_bound, lcnt_q <= LC_W'(LARGE_DEPTH))
  `SFLA_ASSERT(a_gnt_ok, $rose(out_valid_q) |-> !(out_gnt_q && out_st_q != ST_OK))
  `SFLA_ASSERT(a_sum_when, !$stable(sum_q) |-> ($past(state_q) == S_EXEC || $past(state_q) == S_SCAN))

endmodule
`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import sfla_pkg::*;

  typedef struct packed {
    opcode_e          op;
    logic [AddrW-1:0] addr;
    logic [SizeW-1:0] size;
  } alloc_req_t;

  typedef struct packed {
    logic               granted;
    logic [AddrW-1:0]   gaddr;
    status_e            status;
    logic [CountW-1:0]  blocks;
    logic [AddrW-1:0]   words;
  } alloc_rsp_t;

  logic clk_i;
  logic rst_ni;

  sfla_req_if req_if ();
  sfla_rsp_if rsp_if ();

  segregated_free_list_allocator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // predictor state
  logic [AddrW-1:0] stack_addr [SmallClasses][SmallDepth];
  int               stack_fill [SmallClasses];
  logic [AddrW-1:0] big_addr [LargeDepth];
  int unsigned      big_size [LargeDepth];
  int               big_count;
  logic [AddrW-1:0] word_sum;

  alloc_req_t pending_reqs[$];
  alloc_rsp_t expected_rsps[$];
  int         n_errors = 0;
  int         n_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // allocator behavior for one request
  function automatic alloc_rsp_t predict_alloc(alloc_req_t r);
    alloc_rsp_t o;
    int unsigned sz;
    int n;
    o = '0;
    o.status = ST_OK;
    sz = r.size;
    if (r.op == OP_FREE) begin
      if (sz > MaxBlockWords) begin
        o.status = ST_OVERSIZE;
      end else if (sz != 0) begin
        if (sz < SmallClasses) begin
          if (stack_fill[sz] >= SmallDepth) begin
            o.status = ST_FULL;
          end else begin
            stack_addr[sz][stack_fill[sz]] = r.addr;
            stack_fill[sz]++;
            word_sum += sz;
          end
        end else if (big_count >= LargeDepth) begin
          o.status = ST_FULL;
        end else begin
          big_addr[big_count] = r.addr;
          big_size[big_count] = sz;
          big_count++;
          word_sum += sz;
        end
      end
    end else if (sz != 0) begin
      if (sz < SmallClasses && stack_fill[sz] > 0) begin
        stack_fill[sz]--;
        o.granted = 1'b1;
        o.gaddr = stack_addr[sz][stack_fill[sz]];
        word_sum -= sz;
      end else begin
        for (int i = 0; i < big_count; i++) begin
          if (big_size[i] >= sz) begin
            o.granted = 1'b1;
            o.gaddr = big_addr[i];
            if (big_size[i] > sz) begin
              big_addr[i] += sz;
              big_size[i] -= sz;
            end else begin
              big_count--;
              big_addr[i] = big_addr[big_count];
              big_size[i] = big_size[big_count];
            end
            word_sum -= sz;
            break;
          end
        end
      end
    end
    n = big_count;
    foreach (stack_fill[c]) n += stack_fill[c];
    o.blocks = n[CountW-1:0];
    o.words = word_sum;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [AddrW-1:0] got, logic [AddrW-1:0] exp);
    $display("mismatch %s: got %0h expected %0h", what, got, exp);
    n_errors++;
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic alloc_req_t mk(opcode_e op, logic [AddrW-1:0] a, int unsigned s);
    alloc_req_t r;
    r.op = op;
    r.addr = a;
    r.size = s[SizeW-1:0];
    return r;
  endfunction

  // driver
  int drv_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.opcode <= 1'b0;
      req_if.block_address <= '0;
      req_if.block_size <= '0;
      drv_gap = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_rsps.push_back(predict_alloc(pending_reqs.pop_front()));
        drv_gap = gap_len();
      end
      if ((!req_if.valid || req_if.ready) || !req_if.valid) begin
        if (req_if.valid && !req_if.ready) begin
        end else if (drv_gap > 0 || pending_reqs.size() == 0) begin
          if (drv_gap > 0) drv_gap--;
          req_if.valid <= 1'b0;
        end else begin
          req_if.valid <= 1'b1;
          req_if.opcode <= pending_reqs[0].op;
          req_if.block_address <= pending_reqs[0].addr;
          req_if.block_size <= pending_reqs[0].size;
        end
      end
    end
  end

  // monitor and ready pattern
  int mon_stall;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      mon_stall = 0;
    end else begin
      n_cycles++;
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected response", '0, '0);
        end else begin
          alloc_rsp_t e;
          e = expected_rsps.pop_front();
          if (rsp_if.granted !== e.granted) report_mismatch("granted", rsp_if.granted, e.granted);
          if (rsp_if.granted_address !== e.gaddr)
            report_mismatch("granted_address", rsp_if.granted_address, e.gaddr);
          if (rsp_if.status !== e.status) report_mismatch("status", rsp_if.status, e.status);
          if (rsp_if.free_block_count !== e.blocks)
            report_mismatch("free_block_count", rsp_if.free_block_count, e.blocks);
          if (rsp_if.free_word_total !== e.words)
            report_mismatch("free_word_total", rsp_if.free_word_total, e.words);
        end
      end
      if (mon_stall > 0) begin
        mon_stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        mon_stall = gap_len();
      end
    end
  end

  // stimulus and end of run
  initial begin
    int kind;
    int unsigned sz;
    logic [AddrW-1:0] a;
    rst_ni = 1'b0;
    foreach (stack_fill[c]) stack_fill[c] = 0;
    big_count = 0;
    word_sum = '0;

    // directed: extremes and special cases
    pending_reqs.push_back(mk(OP_REQUEST, '0, 5));          // failed small request
    pending_reqs.push_back(mk(OP_REQUEST, '0, 0));          // zero-size request
    pending_reqs.push_back(mk(OP_FREE, 32'hFFFF_FFFF, 0));  // zero-size free
    pending_reqs.push_back(mk(OP_FREE, 32'hFFFF_FFF0, 1));
    pending_reqs.push_back(mk(OP_FREE, 32'h0000_0000, 15));
    pending_reqs.push_back(mk(OP_FREE, 32'hFFFF_FFF0, 65535));
    pending_reqs.push_back(mk(OP_FREE, 32'h1234_5678, 16));
    pending_reqs.push_back(mk(OP_REQUEST, 32'hFFFF_FFFF, 1));
    pending_reqs.push_back(mk(OP_REQUEST, '0, 15));
    pending_reqs.push_back(mk(OP_REQUEST, '0, 100));        // split, address wraps
    pending_reqs.push_back(mk(OP_REQUEST, '0, 65535));      // too big now, fails
    pending_reqs.push_back(mk(OP_REQUEST, '0, 65435));      // exact, last entry moves in
    pending_reqs.push_back(mk(OP_REQUEST, '0, 16));         // exact, empties list
    pending_reqs.push_back(mk(OP_FREE, 32'hAAAA_5555, 3));
    pending_reqs.push_back(mk(OP_FREE, 32'h5555_AAAA, 3));
    pending_reqs.push_back(mk(OP_REQUEST, '0, 3));          // lifo order
    pending_reqs.push_back(mk(OP_REQUEST, '0, 3));
    // fill class 2 to full, plus one more
    for (int i = 0; i <= SmallDepth; i++)
      pending_reqs.push_back(mk(OP_FREE, $urandom(), 2));
    // fill the large list, plus one more
    for (int i = 0; i <= LargeDepth; i++)
      pending_reqs.push_back(mk(OP_FREE, $urandom(), $urandom_range(16, 300)));

    // random mix of frees and requests
    for (int i = 0; i < 120; i++) begin
      kind = $urandom_range(0, 9);
      a = $urandom();
      if (kind < 4) sz = $urandom_range(1, 15);
      else if (kind < 7) sz = $urandom_range(16, 2000);
      else if (kind < 8) sz = $urandom_range(0, 65535);
      else sz = $urandom_range(0, 20);
      pending_reqs.push_back(mk(($urandom_range(0, 9) < 5) ? OP_FREE : OP_REQUEST, a, sz));
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (n_errors == 0 && expected_rsps.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    wait (n_cycles >= 1500000);
    $display("tb_top: FAIL");
    $finish;
  end
endmodule
